@@ sv/dgbs_pkg.sv @@
// Shared types and constants of the dual Gaussian background subtraction core.
package dgbs_pkg;

    localparam int PIXEL_COUNT = 65536;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int DIV_STEPS   = 8;

    localparam logic [5:0] MATCH_GATE_RST = 6'd9;
    localparam logic [5:0] FG_FACTOR_RST  = 6'd5;
    localparam logic [3:0] AGE_CAP_RST    = 4'd10;
    localparam logic [7:0] VAR_INIT_RST   = 8'd255;
    localparam logic [7:0] VAR_MAX        = 8'd255;
    localparam logic [3:0] AGE_FRESH      = 4'd1;

    typedef enum logic [1:0] {
        CFG_MATCH_GATE = 2'd0,
        CFG_FG_FACTOR  = 2'd1,
        CFG_AGE_CAP    = 2'd2,
        CFG_VAR_INIT   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_APP  = 2'd0,
        SEL_CAND = 2'd1,
        SEL_NONE = 2'd2
    } upd_sel_t;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [7:0]  pixel_value;
    } in_item_t;

    typedef struct packed {
        logic       foreground;
        logic [7:0] background_mean;
    } out_item_t;

    typedef struct packed {
        logic [7:0] mean;
        logic [7:0] variance;
        logic [3:0] age;
    } model_t;

    typedef struct packed {
        model_t app;
        model_t cand;
    } entry_t;

endpackage

@@ sv/dual_gaussian_background_subtract_core.sv @@
// Top level of the dual Gaussian background subtraction core.

// One pixel is accepted per clock while the output is not stalled, no hazard
// holds it off and the memory is not being cleared. Each result comes from the
// model pipeline, whose two 8-bit quotients are produced one bit per stage. The
// per-pixel models live in one synchronous memory of PIXEL_COUNT entries that
// is read when a pixel is accepted and written back at the end of the divider.
// A pixel whose index matches one still in that read-to-write-back window is
// held off until the older update has landed. After reset the core clears all
// PIXEL_COUNT (65536) entries of the memory before it takes its first pixel;
// configuration writes are taken at any time.
module dual_gaussian_background_subtract_core
    import dgbs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_payload,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_payload,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata
);

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [7:0]        x;
        model_t            app;
        model_t            cand;
    } ctx_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [7:0]        x;
    } st1_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        logic [15:0] d2_app;
        logic [15:0] d2_cand;
        logic [17:0] lim_app;
        logic [17:0] lim_cand;
    } st2_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        upd_sel_t    sel;
        logic [7:0]  m;
        logic [7:0]  v;
        logic [3:0]  a_eff;
        logic [3:0]  am1;
        logic [7:0]  a2;
        logic [15:0] d2;
    } st3_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        upd_sel_t    sel;
        logic [3:0]  a_eff;
        logic [3:0]  am1;
        logic [15:0] t1;
        logic [19:0] t2;
        logic [11:0] nm;
        logic [11:0] a3;
    } st4_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        upd_sel_t    sel;
        logic [3:0]  a_eff;
        logic [3:0]  am1;
        logic [19:0] s;
        logic [11:0] nm;
        logic [11:0] a3;
    } st5_t;

    typedef struct packed {
        logic        valid;
        ctx_t        ctx;
        upd_sel_t    sel;
        logic [23:0] rem_v;
        logic [11:0] den_v;
        logic [7:0]  q_v;
        logic        sat;
        logic [11:0] rem_m;
        logic [3:0]  den_m;
        logic [7:0]  q_m;
    } div_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] mean;
        logic [7:0] e;
        logic [7:0] x;
    } f1_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  mean;
        logic [15:0] e2;
        logic [15:0] fgp;
    } f2_t;

    // One restoring division step for quotient bit b of both divisions.
    function automatic div_t div_step(input div_t d, input logic [2:0] b);
        div_t        r;
        logic [23:0] dv_sh;
        logic [11:0] dm_sh;
        r     = d;
        dv_sh = 24'(d.den_v) << b;
        dm_sh = 12'(d.den_m) << b;
        if (b == 3'(DIV_STEPS - 1)) begin
            r.sat = (d.rem_v >= (24'(d.den_v) << DIV_STEPS));
        end
        if (d.rem_v >= dv_sh) begin
            r.rem_v  = d.rem_v - dv_sh;
            r.q_v[b] = 1'b1;
        end
        if (d.rem_m >= dm_sh) begin
            r.rem_m  = d.rem_m - dm_sh;
            r.q_m[b] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers
    logic [5:0] match_gate_reg;
    logic [5:0] fg_factor_reg;
    logic [3:0] age_cap_reg;
    logic [7:0] var_init_reg;

    // Memory and clearing pass
    entry_t            model_mem [PIXEL_COUNT];
    entry_t            rd_data_reg;
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    // Pipeline
    st1_t      st1_reg;
    st2_t      st2_reg, st2_next;
    st3_t      st3_reg, st3_next;
    st4_t      st4_reg, st4_next;
    st5_t      st5_reg, st5_next;
    div_t      dv_reg  [DIV_STEPS+1];
    div_t      dv_next [DIV_STEPS+1];
    f1_t       f1_reg, f1_next;
    f2_t       f2_reg, f2_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg;

    logic              adv;
    logic              hazard;
    logic              s_accept;
    logic [ADDR_W-1:0] s_addr;
    logic [7:0]        d_app, d_cand;
    logic [11:0]       vl_app, vl_cand;
    logic              hit_app, hit_cand;
    logic [3:0]        sel_age;
    model_t            fin_app, fin_cand, upd_model, fresh_model;
    logic [3:0]        orig_age;
    logic [9:0]        x_lim;

    // Whole pipeline moves unless a finished item is blocked by a full output.
    assign adv      = !(f2_reg.valid && out_valid_reg && !m_ready);
    assign s_addr   = ADDR_W'(s_payload.pixel_index % PIXEL_COUNT);
    assign s_ready  = adv && !hazard && !clr_active_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_payload = out_reg;

    // Any in-flight pixel between read and write-back at the same location.
    always_comb begin
        hazard = st1_reg.valid && (st1_reg.idx == s_addr);
        if (st2_reg.valid && (st2_reg.ctx.idx == s_addr)) hazard = 1'b1;
        if (st3_reg.valid && (st3_reg.ctx.idx == s_addr)) hazard = 1'b1;
        if (st4_reg.valid && (st4_reg.ctx.idx == s_addr)) hazard = 1'b1;
        if (st5_reg.valid && (st5_reg.ctx.idx == s_addr)) hazard = 1'b1;
        for (int k = 0; k <= DIV_STEPS; k++) begin
            if (dv_reg[k].valid && (dv_reg[k].ctx.idx == s_addr)) hazard = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_gate_reg <= MATCH_GATE_RST;
            fg_factor_reg  <= FG_FACTOR_RST;
            age_cap_reg    <= AGE_CAP_RST;
            var_init_reg   <= VAR_INIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MATCH_GATE: match_gate_reg <= cfg_wdata[5:0];
                CFG_FG_FACTOR:  fg_factor_reg  <= cfg_wdata[5:0];
                CFG_AGE_CAP:    age_cap_reg    <= cfg_wdata[3:0];
                CFG_VAR_INIT:   var_init_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(PIXEL_COUNT - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Stage 1: models read from memory; differences and gate limits.
    always_comb begin
        d_app   = abs_diff(st1_reg.x, rd_data_reg.app.mean);
        d_cand  = abs_diff(st1_reg.x, rd_data_reg.cand.mean);
        vl_app  = (rd_data_reg.app.variance == '0) ? 12'd1
                                                   : 12'(rd_data_reg.app.variance) * 12'd10;
        vl_cand = (rd_data_reg.cand.variance == '0) ? 12'd1
                                                    : 12'(rd_data_reg.cand.variance) * 12'd10;
        st2_next.valid    = st1_reg.valid;
        st2_next.ctx.idx  = st1_reg.idx;
        st2_next.ctx.x    = st1_reg.x;
        st2_next.ctx.app  = rd_data_reg.app;
        st2_next.ctx.cand = rd_data_reg.cand;
        st2_next.d2_app   = 16'(d_app) * 16'(d_app);
        st2_next.d2_cand  = 16'(d_cand) * 16'(d_cand);
        st2_next.lim_app  = 18'(match_gate_reg) * 18'(vl_app);
        st2_next.lim_cand = 18'(match_gate_reg) * 18'(vl_cand);
    end

    // Stage 2: match tests and choice of the model to update.
    always_comb begin
        hit_app  = (20'(st2_reg.d2_app) * 20'd10) < 20'(st2_reg.lim_app);
        hit_cand = (20'(st2_reg.d2_cand) * 20'd10) < 20'(st2_reg.lim_cand);
        st3_next.valid = st2_reg.valid;
        st3_next.ctx   = st2_reg.ctx;
        if (hit_app) begin
            st3_next.sel = SEL_APP;
            st3_next.m   = st2_reg.ctx.app.mean;
            st3_next.v   = st2_reg.ctx.app.variance;
            sel_age      = st2_reg.ctx.app.age;
            st3_next.d2  = st2_reg.d2_app;
        end else begin
            st3_next.sel = hit_cand ? SEL_CAND : SEL_NONE;
            st3_next.m   = st2_reg.ctx.cand.mean;
            st3_next.v   = st2_reg.ctx.cand.variance;
            sel_age      = st2_reg.ctx.cand.age;
            st3_next.d2  = st2_reg.d2_cand;
        end
        st3_next.a_eff = (sel_age == '0) ? 4'd1 : sel_age;
        st3_next.am1   = st3_next.a_eff - 4'd1;
        st3_next.a2    = 8'(st3_next.a_eff) * 8'(st3_next.a_eff);
    end

    // Stage 3: partial products of both numerators and the cube of the age.
    always_comb begin
        st4_next.valid = st3_reg.valid;
        st4_next.ctx   = st3_reg.ctx;
        st4_next.sel   = st3_reg.sel;
        st4_next.a_eff = st3_reg.a_eff;
        st4_next.am1   = st3_reg.am1;
        st4_next.t1    = 16'(st3_reg.a2) * 16'(st3_reg.v);
        st4_next.t2    = 20'(st3_reg.am1) * 20'(st3_reg.d2);
        st4_next.nm    = 12'(st3_reg.am1) * 12'(st3_reg.m) + 12'(st3_reg.ctx.x);
        st4_next.a3    = 12'(st3_reg.a2) * 12'(st3_reg.a_eff);
    end

    // Stage 4: inner sum of the variance numerator.
    always_comb begin
        st5_next.valid = st4_reg.valid;
        st5_next.ctx   = st4_reg.ctx;
        st5_next.sel   = st4_reg.sel;
        st5_next.a_eff = st4_reg.a_eff;
        st5_next.am1   = st4_reg.am1;
        st5_next.s     = 20'(st4_reg.t1) + st4_reg.t2;
        st5_next.nm    = st4_reg.nm;
        st5_next.a3    = st4_reg.a3;
    end

    // Stage 5 loads the divider; the following stages each settle one quotient bit.
    always_comb begin
        dv_next[0].valid = st5_reg.valid;
        dv_next[0].ctx   = st5_reg.ctx;
        dv_next[0].sel   = st5_reg.sel;
        dv_next[0].rem_v = 24'(st5_reg.am1) * 24'(st5_reg.s);
        dv_next[0].den_v = st5_reg.a3;
        dv_next[0].q_v   = '0;
        dv_next[0].sat   = 1'b0;
        dv_next[0].rem_m = st5_reg.nm;
        dv_next[0].den_m = st5_reg.a_eff;
        dv_next[0].q_m   = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            dv_next[k+1] = div_step(dv_reg[k], 3'(DIV_STEPS - 1 - k));
        end
    end

    // Write-back: apply the update, the candidate reset and the swap.
    always_comb begin
        fresh_model.mean     = dv_reg[DIV_STEPS].ctx.x;
        fresh_model.variance = var_init_reg;
        fresh_model.age      = AGE_FRESH;
        orig_age = (dv_reg[DIV_STEPS].sel == SEL_APP) ? dv_reg[DIV_STEPS].ctx.app.age
                                                      : dv_reg[DIV_STEPS].ctx.cand.age;
        upd_model.mean     = dv_reg[DIV_STEPS].q_m;
        upd_model.variance = dv_reg[DIV_STEPS].sat ? VAR_MAX : dv_reg[DIV_STEPS].q_v;
        upd_model.age      = (orig_age < age_cap_reg) ? orig_age + 4'd1 : orig_age;
        fin_app  = dv_reg[DIV_STEPS].ctx.app;
        fin_cand = dv_reg[DIV_STEPS].ctx.cand;
        case (dv_reg[DIV_STEPS].sel)
            SEL_APP:  fin_app  = upd_model;
            SEL_CAND: fin_cand = upd_model;
            SEL_NONE: fin_cand = fresh_model;
            default:  fin_cand = fresh_model;
        endcase
        if (fin_cand.age > fin_app.age) begin
            fin_app  = fin_cand;
            fin_cand = fresh_model;
        end
        mem_wdata.app  = fin_app;
        mem_wdata.cand = fin_cand;
        f1_next.valid  = dv_reg[DIV_STEPS].valid;
        f1_next.mean   = fin_app.mean;
        f1_next.e      = abs_diff(fin_app.mean, dv_reg[DIV_STEPS].ctx.x);
        f1_next.x      = dv_reg[DIV_STEPS].ctx.x;
    end

    // Memory write port: clearing pass first, otherwise the retiring update.
    always_comb begin
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end else begin
            mem_we    = adv && dv_reg[DIV_STEPS].valid;
            mem_waddr = dv_reg[DIV_STEPS].ctx.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            if (clr_active_reg) begin
                model_mem[mem_waddr] <= '{app:  '{mean: 8'd0, variance: 8'd0, age: AGE_FRESH},
                                          cand: '{mean: 8'd0, variance: 8'd0, age: AGE_FRESH}};
            end else begin
                model_mem[mem_waddr] <= mem_wdata;
            end
        end
        if (s_accept) begin
            rd_data_reg <= model_mem[s_addr];
        end
    end

    // Foreground test terms.
    always_comb begin
        x_lim          = (f1_reg.x == '0) ? 10'd1 : {f1_reg.x, 2'b00};
        f2_next.valid  = f1_reg.valid;
        f2_next.mean   = f1_reg.mean;
        f2_next.e2     = 16'(f1_reg.e) * 16'(f1_reg.e);
        f2_next.fgp    = 16'(fg_factor_reg) * 16'(x_lim);
        out_next.foreground      = (18'(f2_reg.e2) << 2) > 18'(f2_reg.fgp);
        out_next.background_mean = f2_reg.mean;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.valid <= 1'b0;
            st2_reg.valid <= 1'b0;
            st3_reg.valid <= 1'b0;
            st4_reg.valid <= 1'b0;
            st5_reg.valid <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_reg[k].valid <= 1'b0;
            end
            f1_reg.valid <= 1'b0;
            f2_reg.valid <= 1'b0;
        end else if (adv) begin
            st1_reg.valid <= s_accept;
            st1_reg.idx   <= s_addr;
            st1_reg.x     <= s_payload.pixel_value;
            st2_reg       <= st2_next;
            st3_reg       <= st3_next;
            st4_reg       <= st4_next;
            st5_reg       <= st5_next;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

    // Output register: holds a result until its transfer, refills from the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= f2_reg.valid;
            out_reg       <= out_next;
        end
    end

endmodule

@@ tb/sv/dual_gaussian_background_subtract_core_test.sv @@
// Self-checking testbench of the dual Gaussian background subtraction core.
module dual_gaussian_background_subtract_core_test;
    import dgbs_pkg::*;

    // The memory clearing pass after reset is the longest quiet stretch of a good run.
    localparam int QUIET_LIMIT   = 4 * PIXEL_COUNT;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int SPOT_COUNT    = 16;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_payload = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_payload;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_MATCH_GATE;
    logic [7:0] cfg_wdata = '0;

    // Shadow copy of the per-pixel models and of the registers.
    model_t     app_models  [PIXEL_COUNT];
    model_t     cand_models [PIXEL_COUNT];
    logic [5:0] gate_mirror = MATCH_GATE_RST;
    logic [5:0] fg_mirror   = FG_FACTOR_RST;
    logic [3:0] cap_mirror  = AGE_CAP_RST;
    logic [7:0] var_mirror  = VAR_INIT_RST;

    out_item_t  expected_results [$];
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    bit         src_bursts   = 1'b1;
    bit         sink_bursts  = 1'b1;

    dual_gaussian_background_subtract_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned abs_diff(input longint unsigned a,
                                                 input longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit gate_hit(input logic [7:0] x, input model_t mdl);
        longint unsigned d;
        longint unsigned lim;
        d   = abs_diff(x, mdl.mean);
        lim = 10 * longint'(mdl.variance);
        if (lim < 1)
            lim = 1;
        return (10 * d * d) < (longint'(gate_mirror) * lim);
    endfunction

    function automatic model_t refine_model(input model_t mdl, input logic [7:0] xv);
        longint unsigned a;
        longint unsigned d;
        longint unsigned x;
        longint unsigned nm;
        longint unsigned nv;
        x = xv;
        a = mdl.age;
        if (a == 0)
            a = 1;
        d  = abs_diff(x, mdl.mean);
        nm = ((a - 1) * longint'(mdl.mean) + x) / a;
        nv = (a - 1) * (a * a * longint'(mdl.variance) + (a - 1) * d * d) / (a * a * a);
        if (nv > 255)
            nv = 255;
        mdl.mean     = nm[7:0];
        mdl.variance = nv[7:0];
        // The age grows only while it is below the age cap, as in the core.
        if (mdl.age < cap_mirror)
            mdl.age = mdl.age + 4'd1;
        return mdl;
    endfunction

    function automatic model_t fresh_candidate(input logic [7:0] x);
        model_t mdl;
        mdl.mean     = x;
        mdl.variance = var_mirror;
        mdl.age      = AGE_FRESH;
        return mdl;
    endfunction

    // Updates the shadow models for one pixel and returns its classification.
    function automatic out_item_t classify_pixel(input in_item_t item);
        int unsigned     p;
        logic [7:0]      x;
        model_t          app;
        model_t          cand;
        longint unsigned e;
        longint unsigned lim;
        out_item_t       res;
        p    = item.pixel_index % PIXEL_COUNT;
        x    = item.pixel_value;
        app  = app_models[p];
        cand = cand_models[p];
        if (gate_hit(x, app))
            app = refine_model(app, x);
        else if (gate_hit(x, cand))
            cand = refine_model(cand, x);
        else
            cand = fresh_candidate(x);
        if (cand.age > app.age) begin
            app  = cand;
            cand = fresh_candidate(x);
        end
        app_models[p]  = app;
        cand_models[p] = cand;
        e   = abs_diff(app.mean, x);
        lim = 4 * longint'(x);
        if (lim < 1)
            lim = 1;
        res.foreground      = ((4 * e * e) <= (longint'(fg_mirror) * lim)) ? 1'b0 : 1'b1;
        res.background_mean = app.mean;
        return res;
    endfunction

    // Valid is only lowered for an idle burst or a drain, never right before being raised.
    task automatic send_pixel(input logic [15:0] idx, input logic [7:0] val);
        in_item_t  item;
        out_item_t res;
        if (src_bursts && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        item.pixel_index = idx;
        item.pixel_value = val;
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        res = classify_pixel(item);
        expected_results = {expected_results, res};
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input logic [7:0] gate, input logic [7:0] fg,
                               input logic [7:0] cap, input logic [7:0] vinit);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MATCH_GATE;
        cfg_wdata <= gate;
        @(posedge aclk);
        cfg_index <= CFG_FG_FACTOR;
        cfg_wdata <= fg;
        @(posedge aclk);
        cfg_index <= CFG_AGE_CAP;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_index <= CFG_VAR_INIT;
        cfg_wdata <= vinit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gate_mirror = gate[5:0];
        fg_mirror   = fg[5:0];
        cap_mirror  = cap[3:0];
        var_mirror  = vinit;
    endtask

    task automatic test_fresh_models();
        send_pixel(16'h0000, 8'h00);
        send_pixel(16'hFFFF, 8'hFF);
        send_pixel(16'h5555, 8'hAA);
        send_pixel(16'hAAAA, 8'h55);
    endtask

    // A steady level builds the apparent model; a new level grows a candidate that takes over.
    task automatic test_learning_and_swap();
        int n;
        for (n = 0; n < 6; n++)
            send_pixel(16'h1234, 8'd100);
        for (n = 0; n < 8; n++)
            send_pixel(16'h1234, 8'd200);
        send_pixel(16'h1234, 8'd0);
        send_pixel(16'h1234, 8'd255);
    endtask

    // No model can match with a zero gate, and ages stay put with a zero cap.
    task automatic test_gate_and_cap_extremes();
        drain_results();
        load_config(8'd0, 8'd63, 8'd0, 8'd0);
        send_pixel(16'h1234, 8'd200);
        send_pixel(16'h1234, 8'd200);
        send_pixel(16'h0000, 8'd0);
        drain_results();
        load_config(8'd63, 8'd1, 8'd15, 8'd255);
        send_pixel(16'h1234, 8'd201);
        send_pixel(16'h1234, 8'd199);
    endtask

    // Most pixels revisit a few locations with a slowly changing level; the rest are noise.
    task automatic test_random_scenes(input int count);
        logic [15:0] spots  [SPOT_COUNT];
        logic [7:0]  levels [SPOT_COUNT];
        int          k;
        int          n;
        int          v;
        for (k = 0; k < SPOT_COUNT; k++) begin
            spots[k]  = 16'($urandom_range(0, 65535));
            levels[k] = 8'($urandom_range(0, 255));
        end
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_pixel(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end else begin
                k = $urandom_range(0, SPOT_COUNT - 1);
                if ($urandom_range(0, 99) < 4)
                    levels[k] = 8'($urandom_range(0, 255));
                v = int'(levels[k]) + int'($urandom_range(0, 12)) - 6;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                send_pixel(spots[k], v[7:0]);
            end
        end
    endtask

    task automatic test_random_configs();
        drain_results();
        load_config(8'd9, 8'd5, 8'd10, 8'd255);
        test_random_scenes(400);
        drain_results();
        load_config(8'd63, 8'd63, 8'd15, 8'd0);
        test_random_scenes(300);
        drain_results();
        load_config(8'd1, 8'd1, 8'd1, 8'd128);
        test_random_scenes(300);
        drain_results();
        load_config(8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                    8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        test_random_scenes(300);
    endtask

    // Back-to-back transfers on both sides; the upper register bits must be dropped.
    task automatic test_streaming();
        drain_results();
        load_config(8'hC9, 8'h45, 8'hFA, 8'hFF);
        src_bursts  = 1'b0;
        sink_bursts = 1'b0;
        test_random_scenes(625);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (sink_bursts && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: foreground=%0d mean=%0d",
                             m_payload.foreground, m_payload.background_mean);
            end else begin
                want = expected_results.pop_front();
                if (m_payload.foreground !== want.foreground ||
                    m_payload.background_mean !== want.background_mean) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected foreground=%0d mean=%0d, got %0d %0d",
                                 want.foreground, want.background_mean,
                                 m_payload.foreground, m_payload.background_mean);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            app_models[i]  = '{mean: 8'd0, variance: 8'd0, age: AGE_FRESH};
            cand_models[i] = '{mean: 8'd0, variance: 8'd0, age: AGE_FRESH};
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_fresh_models();
        test_learning_and_swap();
        test_gate_and_cap_extremes();
        test_random_configs();
        test_streaming();
        drain_results();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ dual_gaussian_background_subtract_core.f @@
sv/dgbs_pkg.sv
sv/dual_gaussian_background_subtract_core.sv
tb/sv/dual_gaussian_background_subtract_core_test.sv
